/* sv/rpbp_pkg.sv */
// Package for the raster-to-page byte packer: field widths, register indexes,
// command and result types shared by the front end, the back end and the top level.
// No dependencies.
`default_nettype none

package rpbp_pkg;

  // Field widths.
  localparam int COL_W       = 7;
  localparam int ROW_W       = 3;
  localparam int PAGE_W      = 3;
  localparam int BYTE_W      = 8;
  localparam int PART_W      = BYTE_W - 1;
  localparam int COLS_CFG_W  = 8;
  localparam int PAGES_CFG_W = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;

  // Hardware limits of the position counters.
  localparam int COL_LIMIT     = 1 << COL_W;
  localparam int PAGE_LIMIT    = 1 << PAGE_W;
  localparam int ROWS_PER_PAGE = 8;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS_PER_PAGE - 1);

  // Default sizes of the frame store.
  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 64;

  // Queue depths between the stages.
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Register reset values.
  localparam logic [COLS_CFG_W-1:0]  COLS_RESET  = COLS_CFG_W'(COL_LIMIT);
  localparam logic [PAGES_CFG_W-1:0] PAGES_RESET = PAGES_CFG_W'(PAGE_LIMIT);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS_IN_USE = 1'b0,
    REG_PAGES_IN_USE   = 1'b1
  } rpbp_reg_e;

  // What the back end does with one pixel.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,  // top row of a page: start a new partial byte
    OP_MERGE = 2'd1,  // middle rows: OR the pixel into the partial byte
    OP_EMIT  = 2'd2   // bottom row: complete the byte and send it out
  } rpbp_op_e;

  // Classified pixel handed from the front end to the back end.
  typedef struct packed {
    rpbp_op_e         op;
    logic             pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PAGE_W-1:0] page;
    logic             last;
  } rpbp_cmd_t;

  // One finished page byte.
  typedef struct packed {
    logic [BYTE_W-1:0] page_byte;
    logic [COL_W-1:0]  column;
    logic [PAGE_W-1:0] page;
    logic              last_of_frame;
  } rpbp_res_t;

endpackage

`default_nettype wire

/* sv/raster_to_page_byte_packer.sv */
// Raster-to-page byte packer, top level. Uses rpbp_pkg, rpbp_front, rpbp_back
// and rpbp_fifo.
//
// Pixels enter one per transaction on the input queue (push, full) in raster
// order, with frame_start_i on the first pixel of a frame. Every eighth row
// of a page completes a byte of eight vertical pixels, top row in bit 0; it
// leaves on the result queue (empty, pop) with its column, page and a flag on
// the frame's final byte. Other pixels produce no transaction.
// Configuration (columns and pages in use) is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write it only while the block is
// idle, which the block itself does not enforce. Throughput is one pixel per
// cycle while the result queue has room: the partial byte memory does one read
// and one write per cycle, with forwarding when a column is hit twice in a row.
// When the receiver stalls, the result queue and then the command queue fill,
// and full rises after a few more pixels. Reset restores 128 columns, 8 pages
// and the frame origin; the partial byte memory is not cleared.
`default_nettype none

module raster_to_page_byte_packer
  import rpbp_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  pixel_i,
  input  wire logic                  frame_start_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [BYTE_W-1:0]          page_byte_o,
  output logic [COL_W-1:0]           column_o,
  output logic [PAGE_W-1:0]          page_o,
  output logic                       last_of_frame_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic      accept;
  rpbp_cmd_t front_cmd, back_cmd;
  logic      cmd_empty, cmd_pop;
  rpbp_res_t back_res, out_res;
  logic      res_push, res_full;

  assign accept = push && !full;

  // Position tracking and classification.
  rpbp_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_o         (front_cmd)
  );

  // Command queue between front and back.
  rpbp_fifo #(
    .WIDTH ($bits(rpbp_cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (front_cmd),
    .pop_i   (cmd_pop),
    .rdata_o (back_cmd),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  // Partial byte memory and byte assembly.
  rpbp_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // Result queue toward the receiver.
  rpbp_fifo #(
    .WIDTH ($bits(rpbp_res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .pop_i   (pop),
    .rdata_o (out_res),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign page_byte_o     = out_res.page_byte;
  assign column_o        = out_res.column;
  assign page_o          = out_res.page;
  assign last_of_frame_o = out_res.last_of_frame;

endmodule

`default_nettype wire

/* sv/rpbp_fifo.sv */
// Small flip-flop queue used between the packer stages.
// No package dependencies; width and depth come from the instantiating module.
`default_nettype none

module rpbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign rdata_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* sv/rpbp_front.sv */
// Front end of the packer: configuration registers, raster position counters
// and classification of each pixel into a back-end command. Uses rpbp_pkg.
`default_nettype none

module rpbp_front
  import rpbp_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic                  pixel_i,
  input  wire logic                  frame_start_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output rpbp_cmd_t                  cmd_o
);

  // Hardware limits that the register values are saturated to.
  localparam int HwCols   = (MAX_COLUMNS < COL_LIMIT) ? MAX_COLUMNS : COL_LIMIT;
  localparam int RowPages = MAX_ROWS / ROWS_PER_PAGE;
  localparam int HwPages  = (RowPages > PAGE_LIMIT) ? PAGE_LIMIT :
                            ((RowPages < 1) ? 1 : RowPages);
  localparam logic [COLS_CFG_W-1:0]  HwColsV  = COLS_CFG_W'(HwCols);
  localparam logic [PAGES_CFG_W-1:0] HwPagesV = PAGES_CFG_W'(HwPages);
  localparam bit              ColClamp = (MAX_COLUMNS < COL_LIMIT);
  localparam logic [COL_W-1:0] ColMaxV = COL_W'(ColClamp ? MAX_COLUMNS : 0);

  logic [COLS_CFG_W-1:0]  cfg_cols_q;
  logic [PAGES_CFG_W-1:0] cfg_pages_q;
  logic [COLS_CFG_W-1:0]  cols_eff;
  logic [PAGES_CFG_W-1:0] pages_eff;

  logic [COL_W-1:0]  col_q, col_d, col_cur;
  logic [ROW_W-1:0]  row_q, row_d, row_cur;
  logic [PAGE_W-1:0] page_q, page_d, page_cur;
  logic [COL_W:0]    col_inc;
  logic [PAGE_W:0]   page_inc;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q  <= COLS_RESET;
      cfg_pages_q <= PAGES_RESET;
    end else if (cfg_we_i) begin
      unique case (rpbp_reg_e'(cfg_idx_i))
        REG_COLUMNS_IN_USE: cfg_cols_q  <= cfg_wdata_i[COLS_CFG_W-1:0];
        REG_PAGES_IN_USE:   cfg_pages_q <= cfg_wdata_i[PAGES_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the limits into the supported range.
  always_comb begin
    cols_eff = cfg_cols_q;
    if (cfg_cols_q == '0) begin
      cols_eff = COLS_CFG_W'(1);
    end else if (cfg_cols_q > HwColsV) begin
      cols_eff = HwColsV;
    end
    pages_eff = cfg_pages_q;
    if (cfg_pages_q == '0) begin
      pages_eff = PAGES_CFG_W'(1);
    end else if (cfg_pages_q > HwPagesV) begin
      pages_eff = HwPagesV;
    end
  end

  // Current position, classification and next position.
  always_comb begin
    col_cur  = frame_start_i ? '0 : col_q;
    row_cur  = frame_start_i ? '0 : row_q;
    page_cur = frame_start_i ? '0 : page_q;
    if (ColClamp && (col_cur >= ColMaxV)) begin
      col_cur = '0;
    end
    col_inc  = {1'b0, col_cur} + (COL_W + 1)'(1);
    page_inc = {1'b0, page_cur} + (PAGE_W + 1)'(1);

    cmd_o.pixel = pixel_i;
    cmd_o.row   = row_cur;
    cmd_o.col   = col_cur;
    cmd_o.page  = page_cur;
    cmd_o.last  = (PAGES_CFG_W'(page_inc) >= pages_eff) &&
                  (COLS_CFG_W'(col_inc) >= cols_eff);
    if (row_cur == '0) begin
      cmd_o.op = OP_LOAD;
    end else if (row_cur == ROW_LAST) begin
      cmd_o.op = OP_EMIT;
    end else begin
      cmd_o.op = OP_MERGE;
    end

    col_d  = col_inc[COL_W-1:0];
    row_d  = row_cur;
    page_d = page_cur;
    if (COLS_CFG_W'(col_inc) >= cols_eff) begin
      col_d = '0;
      if (row_cur == ROW_LAST) begin
        row_d  = '0;
        page_d = (PAGES_CFG_W'(page_inc) >= pages_eff) ? '0 : page_inc[PAGE_W-1:0];
      end else begin
        row_d = row_cur + ROW_W'(1);
      end
    end
  end

  // Position counters advance once per accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      page_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      page_q <= page_d;
    end
  end

endmodule

`default_nettype wire

/* sv/rpbp_back.sv */
// Back end of the packer: per-column partial byte memory with a two-stage
// read-modify-write and forwarding, producing finished page bytes. Uses rpbp_pkg.
`default_nettype none

module rpbp_back
  import rpbp_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire rpbp_cmd_t cmd_i,
  input  wire logic      cmd_empty_i,
  output logic           cmd_pop_o,
  input  wire logic      res_full_i,
  output logic           res_push_o,
  output rpbp_res_t      res_o
);

  localparam int MemDepth = (MAX_COLUMNS < COL_LIMIT) ? MAX_COLUMNS : COL_LIMIT;
  localparam int IdxW     = $clog2(MemDepth);

  logic [PART_W-1:0] part_mem_q [MemDepth];
  logic [PART_W-1:0] rd_data_q;
  logic [PART_W-1:0] fwd_data_q;
  logic              fwd_q;
  logic              b_valid_q;
  rpbp_cmd_t         b_cmd_q;

  logic              b_done, a_take, wr_en;
  logic [IdxW-1:0]   rd_idx, wr_idx;
  logic [PART_W-1:0] old_part, new_part;

  // Stage handshakes: the write stage waits only when a byte has no room.
  assign b_done    = b_valid_q && ((b_cmd_q.op != OP_EMIT) || !res_full_i);
  assign a_take    = !cmd_empty_i && (!b_valid_q || b_done);
  assign cmd_pop_o = a_take;
  assign rd_idx    = cmd_i.col[IdxW-1:0];
  assign wr_idx    = b_cmd_q.col[IdxW-1:0];
  assign wr_en     = b_done && (b_cmd_q.op != OP_EMIT);

  // Use the value written in the read cycle when both hit the same column.
  assign old_part = fwd_q ? fwd_data_q : rd_data_q;

  // New partial byte for the column.
  always_comb begin
    case (b_cmd_q.op)
      OP_LOAD:  new_part = PART_W'(b_cmd_q.pixel);
      OP_MERGE: new_part = old_part | (PART_W'(b_cmd_q.pixel) << b_cmd_q.row);
      default:  new_part = old_part;
    endcase
  end

  // Finished byte toward the result queue.
  assign res_push_o          = b_done && (b_cmd_q.op == OP_EMIT);
  assign res_o.page_byte     = {b_cmd_q.pixel, old_part};
  assign res_o.column        = b_cmd_q.col;
  assign res_o.page          = b_cmd_q.page;
  assign res_o.last_of_frame = b_cmd_q.last;

  // Write-stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (a_take) begin
        b_valid_q <= 1'b1;
        fwd_q     <= wr_en && (wr_idx == rd_idx);
      end else if (b_done) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  // Write-stage payload and registered memory read.
  always_ff @(posedge clk_i) begin
    if (a_take) begin
      b_cmd_q    <= cmd_i;
      rd_data_q  <= part_mem_q[rd_idx];
      fwd_data_q <= new_part;
    end
  end

  // Partial byte memory write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      part_mem_q[wr_idx] <= new_part;
    end
  end

`ifndef ASSERT_OFF
  // A held write stage keeps its command until it completes.
  a_hold_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !b_done |=> b_valid_q && $stable(b_cmd_q))
    else $error("write stage lost its command while stalled");

  // Bytes are emitted only for the bottom row of a page.
  a_emit_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && (b_cmd_q.op == OP_EMIT) |-> b_cmd_q.row == ROW_LAST)
    else $error("byte emitted outside the bottom row");

  // A partial byte is started exactly on the top row.
  a_load_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> ((b_cmd_q.op == OP_LOAD) == (b_cmd_q.row == '0)))
    else $error("top row and load command disagree");

  // A taken command is in the write stage on the next cycle.
  a_take_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_take |=> b_valid_q)
    else $error("taken command did not reach the write stage");
`endif

endmodule

`default_nettype wire
